@@ rtl/parameter_layout_validator_macros.svh @@
// Assertion macros shared by the parameter layout validator.
`ifndef PARAMETER_LAYOUT_VALIDATOR_MACROS_SVH
`define PARAMETER_LAYOUT_VALIDATOR_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define PLD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pld_pkg.sv @@
// Types, codes and helper functions of the parameter layout validator.
package pld_pkg;

	localparam int MAX_RANGES_DEF = 64;

	localparam int BUF_W = 21;
	localparam logic [BUF_W-1:0] BUF_LIMIT = 21'(1024 * 1024);

	localparam logic [3:0] TY_SCALAR_LAST = 4'd3;
	localparam logic [3:0] TY_FLOAT2      = 4'd4;
	localparam logic [3:0] TY_FLOAT3      = 4'd5;
	localparam logic [3:0] TY_FLOAT4      = 4'd6;
	localparam logic [3:0] TY_MATRIX4     = 4'd7;
	localparam logic [3:0] TY_TEXTURE     = 4'd8;
	localparam logic [3:0] TY_SAMPLER     = 4'd9;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LAYOUT  = 3'd1,
		ST_TYPE    = 3'd2,
		ST_ARRAY   = 3'd3,
		ST_DEFAULT = 3'd4,
		ST_OVERLAP = 3'd5,
		ST_FAILED  = 3'd6
	} status_t;

	typedef struct packed {
		logic [3:0]  param_type;
		logic [31:0] elem_count;
		logic [31:0] elem_stride;
		logic [31:0] byte_offset;
		logic [31:0] default_size;
	} pld_item_t;

	typedef struct packed {
		status_t          early_status;
		logic             resource;
		status_t          late_status;
		logic [BUF_W-1:0] rng_lo;
		logic [BUF_W-1:0] rng_hi;
	} pld_chk_t;

	function automatic logic [6:0] elem_bytes(input logic [3:0] t);
		logic [6:0] sz;
		sz = 7'd0;
		if (t <= TY_SCALAR_LAST) begin
			sz = 7'd4;
		end else begin
			case (t)
				TY_FLOAT2:  sz = 7'd8;
				TY_FLOAT3:  sz = 7'd12;
				TY_FLOAT4:  sz = 7'd16;
				TY_MATRIX4: sz = 7'd64;
				default:    sz = 7'd0;
			endcase
		end
		return sz;
	endfunction

endpackage

@@ rtl/pld_in_if.sv @@
// Input channel carrying one parameter descriptor per beat.
interface pld_in_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [3:0]  param_type;
	logic [31:0] elem_count;
	logic [31:0] elem_stride;
	logic [31:0] byte_offset;
	logic [31:0] default_size;

	modport source (
		output valid, start_req, param_type, elem_count, elem_stride, byte_offset,
		       default_size,
		input  ready
	);
	modport sink (
		input  valid, start_req, param_type, elem_count, elem_stride, byte_offset,
		       default_size,
		output ready
	);
endinterface

@@ rtl/pld_out_if.sv @@
// Output channel carrying one check result per beat.
interface pld_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [6:0] accepted_count;

	modport source (output valid, status, accepted_count, input ready);
	modport sink (input valid, status, accepted_count, output ready);
endinterface

@@ rtl/parameter_layout_validator.sv @@
// Top level of the parameter layout validator: sequencer, range table and output register.
// An item with no sticky error passes from acceptance to the result register through the
// early and late descriptor check states (the second behind the stride multiplier register),
// an overlap scan over the single read port of the range RAM (one read per stored range,
// then the read latency and a step that closes the scan), the append state and the result
// state. With an empty table the scan issues no read. The table holds up to 64 ranges by
// default, and the next item is accepted once the result register is loaded and the
// sequencer is back in idle. An overlap with a stored range ends the scan early, and the
// item goes straight to the result state. Items that fail the bounds or default checks skip
// the scan, resource descriptors and items that fail earlier skip the late check as well,
// and items of a failed build go straight from acceptance to the result state. A stalled
// output holds the item in the result state. The range RAM needs no clearing after reset,
// since only entries below the fill count are read.
// A new item is taken while the previous result still waits in the output register.
module parameter_layout_validator #(
	parameter int MAX_RANGES = pld_pkg::MAX_RANGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [pld_pkg::BUF_W-1:0] cfg_wr_data,
	pld_in_if.sink                    in_ch,
	pld_out_if.source                 out_ch
);
	`include "parameter_layout_validator_macros.svh"

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int RW = 2 * pld_pkg::BUF_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EARLY  = 6'b000010,
		S_LATE   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_APPEND = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t                    state_q;
	pld_pkg::pld_item_t        item_q;
	pld_pkg::pld_chk_t         chk;
	pld_pkg::status_t          res_q;
	logic [pld_pkg::BUF_W-1:0] buffer_size_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             issue_q;
	logic                      failed_q;
	logic                      vld_s1;
	logic                      out_valid_q;
	logic [2:0]                out_status_q;
	logic [6:0]                out_count_q;
	logic                      accept;
	logic                      rd_en;
	logic                      ram_we;
	logic [RW-1:0]             rd_data;
	logic [pld_pkg::BUF_W-1:0] rd_lo;
	logic [pld_pkg::BUF_W-1:0] rd_hi;
	logic                      hit;
	logic                      out_free;

	assign in_ch.ready    = (state_q == S_IDLE);
	assign accept         = in_ch.valid && in_ch.ready;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.status  = out_status_q;
	assign out_ch.accepted_count = out_count_q;
	assign out_free       = !out_valid_q || out_ch.ready;

	pld_layout u_layout (
		.clk         (clk),
		.item        (item_q),
		.buffer_size (buffer_size_q),
		.chk         (chk)
	);

	// Reads and the append write fall in different states, so they never collide.
	assign rd_en  = (state_q == S_SCAN) && (issue_q < count_q);
	assign ram_we = (state_q == S_APPEND) && (count_q < CW'(MAX_RANGES));

	pld_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_RANGES)
	) u_ranges (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({chk.rng_lo, chk.rng_hi}),
		.rd_en   (rd_en),
		.rd_addr (issue_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign rd_lo = rd_data[RW-1:pld_pkg::BUF_W];
	assign rd_hi = rd_data[pld_pkg::BUF_W-1:0];
	assign hit   = vld_s1 && (chk.rng_lo < rd_hi) && (chk.rng_hi > rd_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= '0;
		end else if (cfg_wr_en) begin
			buffer_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.param_type   <= in_ch.param_type;
			item_q.elem_count   <= in_ch.elem_count;
			item_q.elem_stride  <= in_ch.elem_stride;
			item_q.byte_offset  <= in_ch.byte_offset;
			item_q.default_size <= in_ch.default_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_q        <= pld_pkg::ST_OK;
			count_q      <= '0;
			issue_q      <= '0;
			failed_q     <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_count_q  <= '0;
		end else begin
			// In the result state the output register is reloaded instead of emptied.
			if (out_valid_q && out_ch.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_ch.start_req) begin
							count_q  <= '0;
							failed_q <= 1'b0;
						end
						if (failed_q && !in_ch.start_req) begin
							res_q   <= pld_pkg::ST_FAILED;
							state_q <= S_RESP;
						end else begin
							state_q <= S_EARLY;
						end
					end
				end
				S_EARLY: begin
					if (chk.early_status != pld_pkg::ST_OK || chk.resource) begin
						res_q    <= chk.early_status;
						failed_q <= (chk.early_status != pld_pkg::ST_OK);
						state_q  <= S_RESP;
					end else begin
						state_q <= S_LATE;
					end
				end
				S_LATE: begin
					issue_q <= '0;
					vld_s1  <= 1'b0;
					if (chk.late_status != pld_pkg::ST_OK) begin
						res_q    <= chk.late_status;
						failed_q <= 1'b1;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// One read is issued per cycle while the previous entry is compared.
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					vld_s1 <= rd_en;
					if (hit) begin
						res_q    <= pld_pkg::ST_OVERLAP;
						failed_q <= 1'b1;
						state_q  <= S_RESP;
					end else if (!rd_en && !vld_s1) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (ram_we) begin
						count_q <= count_q + CW'(1);
						res_q   <= pld_pkg::ST_OK;
					end else begin
						res_q    <= pld_pkg::ST_LAYOUT;
						failed_q <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_q;
						out_count_q  <= 7'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PLD_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_RANGES), "range count beyond table depth")
	`PLD_ASSERT_NEXT(a_failed_short, accept && failed_q && !in_ch.start_req, state_q == S_RESP && res_q == pld_pkg::ST_FAILED, "failed build item not answered at once")
	`PLD_ASSERT_NEXT(a_failed_sticky, failed_q && !(accept && in_ch.start_req), failed_q, "sticky error cleared without a start item")
	`PLD_ASSERT_ALWAYS(a_no_rw_mix, !(ram_we && rd_en), "range table read and written in one cycle")
endmodule

@@ rtl/pld_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ rtl/pld_layout.sv @@
// Descriptor checks: buffer size, resource rules, type, array, span, bounds and default length.
module pld_layout (
	input  logic                        clk,
	input  pld_pkg::pld_item_t          item,
	input  logic [pld_pkg::BUF_W-1:0]   buffer_size,
	output pld_pkg::pld_chk_t           chk
);
	logic [6:0]  esz;
	logic        bs_bad;
	logic        is_res;
	logic [31:0] cnt_m1;
	logic [63:0] prod_c;
	logic [63:0] prod_s1;
	logic [63:0] span;
	logic [63:0] end_c;

	assign esz    = pld_pkg::elem_bytes(item.param_type);
	assign bs_bad = (buffer_size > pld_pkg::BUF_LIMIT) || (buffer_size[1:0] != 2'd0);
	assign is_res = (item.param_type == pld_pkg::TY_TEXTURE) ||
	                (item.param_type == pld_pkg::TY_SAMPLER);

	// The span of all but the last element is formed in the first check cycle.
	assign cnt_m1 = item.elem_count - 32'd1;
	assign prod_c = item.elem_stride * cnt_m1;

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

	assign span  = prod_s1 + 64'(esz);
	assign end_c = span + 64'(item.byte_offset);

	always_comb begin
		chk.resource     = is_res;
		chk.early_status = pld_pkg::ST_OK;
		if (bs_bad) begin
			chk.early_status = pld_pkg::ST_LAYOUT;
		end else if (is_res) begin
			if (item.elem_count != 32'd1 || item.byte_offset != 32'd0 ||
			    item.elem_stride != 32'd0 || item.default_size != 32'd0) begin
				chk.early_status = pld_pkg::ST_LAYOUT;
			end
		end else if (esz == 7'd0) begin
			chk.early_status = pld_pkg::ST_TYPE;
		end else if (item.elem_count == 32'd0 ||
		             (item.elem_count > 32'd1 &&
		              (item.elem_stride < 32'(esz) || item.elem_stride[1:0] != 2'd0))) begin
			chk.early_status = pld_pkg::ST_ARRAY;
		end

		chk.late_status = pld_pkg::ST_OK;
		if (item.byte_offset[1:0] != 2'd0 || end_c > 64'(buffer_size)) begin
			chk.late_status = pld_pkg::ST_LAYOUT;
		end else if (item.default_size != 32'd0 && 64'(item.default_size) != span) begin
			chk.late_status = pld_pkg::ST_DEFAULT;
		end

		// Past the bounds check both ends lie at or below the buffer size.
		chk.rng_lo = item.byte_offset[pld_pkg::BUF_W-1:0];
		chk.rng_hi = end_c[pld_pkg::BUF_W-1:0];
	end
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the parameter layout validator, with its own layout predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pld_pkg::*;

	localparam logic [3:0] TY_SCALAR_FIRST  = 4'd0;
	localparam logic [3:0] TY_INVALID_FIRST = 4'd10;
	localparam logic [3:0] TY_INVALID_LAST  = 4'd15;
	localparam int unsigned TABLE_DEPTH = MAX_RANGES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		bit          start;
		logic [3:0]  ptype;
		logic [31:0] count;
		logic [31:0] stride;
		logic [31:0] offset;
		logic [31:0] dflt;
	} desc_t;

	typedef struct {
		status_t    status;
		logic [6:0] count;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [BUF_W-1:0] cfg_wr_data;

	pld_in_if in_ch();
	pld_out_if out_ch();

	parameter_layout_validator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	// Predictor state: configured size, accepted ranges and the sticky error.
	logic [BUF_W-1:0] buf_size = '0;
	logic [BUF_W-1:0] range_lo [TABLE_DEPTH];
	logic [BUF_W-1:0] range_hi [TABLE_DEPTH];
	int unsigned range_cnt = 0;
	bit build_failed = 1'b0;

	verdict_t pending_verdicts[$];
	int fail_count = 0;
	int quiet_cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	function automatic logic [6:0] elem_size(logic [3:0] t);
		if (t <= TY_SCALAR_LAST) return 7'd4;
		case (t)
			TY_FLOAT2:  return 7'd8;
			TY_FLOAT3:  return 7'd12;
			TY_FLOAT4:  return 7'd16;
			TY_MATRIX4: return 7'd64;
			default:    return 7'd0;
		endcase
	endfunction

	function automatic status_t check_layout(desc_t d);
		logic [6:0] esz;
		logic [63:0] span;
		logic [63:0] fin;
		if (buf_size > BUF_LIMIT || buf_size[1:0] != 2'b00) return ST_LAYOUT;
		if (d.ptype == TY_TEXTURE || d.ptype == TY_SAMPLER) begin
			if (d.count != 32'd1 || d.offset != 32'd0 || d.stride != 32'd0 || d.dflt != 32'd0)
				return ST_LAYOUT;
			return ST_OK;
		end
		esz = elem_size(d.ptype);
		if (esz == 7'd0) return ST_TYPE;
		if (d.count == 32'd0 ||
				(d.count > 32'd1 && (d.stride < 32'(esz) || d.stride[1:0] != 2'b00)))
			return ST_ARRAY;
		span = (d.count == 32'd1) ? 64'(esz)
			: 64'(d.stride) * (64'(d.count) - 64'd1) + 64'(esz);
		fin = 64'(d.offset) + span;
		if (d.offset[1:0] != 2'b00 || fin > 64'(buf_size) || fin > 64'hFFFF_FFFF)
			return ST_LAYOUT;
		if (d.dflt != 32'd0 && 64'(d.dflt) != span) return ST_DEFAULT;
		for (int unsigned i = 0; i < range_cnt; i++) begin
			if (64'(d.offset) < 64'(range_hi[i]) && fin > 64'(range_lo[i])) return ST_OVERLAP;
		end
		if (range_cnt >= TABLE_DEPTH) return ST_LAYOUT;
		range_lo[range_cnt] = d.offset[BUF_W-1:0];
		range_hi[range_cnt] = fin[BUF_W-1:0];
		range_cnt++;
		return ST_OK;
	endfunction

	function automatic verdict_t apply_descriptor(desc_t d);
		verdict_t v;
		if (d.start) begin
			range_cnt = 0;
			build_failed = 1'b0;
		end
		if (build_failed) begin
			v.status = ST_FAILED;
		end else begin
			v.status = check_layout(d);
			if (v.status != ST_OK) build_failed = 1'b1;
		end
		v.count = 7'(range_cnt);
		return v;
	endfunction

	function automatic desc_t make_desc(bit start, logic [3:0] t, logic [31:0] cnt,
			logic [31:0] str, logic [31:0] off, logic [31:0] dflt);
		desc_t d;
		d.start = start;
		d.ptype = t;
		d.count = cnt;
		d.stride = str;
		d.offset = off;
		d.dflt = dflt;
		return d;
	endfunction

	// Mostly well-formed value descriptors placed just past the last range, so that builds
	// grow deep into the table; the rest are resources, single-field breakage and noise.
	function automatic desc_t random_desc();
		desc_t d;
		logic [6:0] esz;
		logic [31:0] cursor;
		logic [31:0] span;
		int unsigned roll;
		d.start = build_failed ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0);
		cursor = (d.start || range_cnt == 0) ? 32'd0 : 32'(range_hi[range_cnt - 1]);
		roll = $urandom_range(0, 99);
		if (roll >= 90) begin
			d.ptype = 4'($urandom_range(0, 15));
			d.count = $urandom;
			d.stride = $urandom;
			d.offset = $urandom;
			d.dflt = $urandom;
			return d;
		end
		if (roll >= 78) begin
			d.ptype = ($urandom_range(0, 1) != 0) ? TY_TEXTURE : TY_SAMPLER;
			d.count = 32'd1;
			d.stride = 32'd0;
			d.offset = 32'd0;
			d.dflt = 32'd0;
			case ($urandom_range(0, 7))
				0: d.count = $urandom;
				1: d.stride = $urandom;
				2: d.offset = $urandom;
				3: d.dflt = $urandom;
				default: ;
			endcase
			return d;
		end
		d.ptype = 4'($urandom_range(TY_SCALAR_FIRST, TY_MATRIX4));
		esz = elem_size(d.ptype);
		d.count = ($urandom_range(0, 2) == 0) ? 32'd1 : 32'($urandom_range(2, 6));
		d.stride = 32'(esz) + 32'(4 * $urandom_range(0, 2));
		d.offset = cursor + 32'(4 * $urandom_range(0, 2));
		// An offset anywhere in the buffer usually lands on an accepted range.
		if ($urandom_range(0, 6) == 0) d.offset = 32'(4 * $urandom_range(0, buf_size >> 2));
		span = (d.count == 32'd1) ? 32'(esz) : d.stride * (d.count - 32'd1) + 32'(esz);
		case ($urandom_range(0, 4))
			0, 1: d.dflt = 32'd0;
			2, 3: d.dflt = span;
			default: d.dflt = 32'(4 * $urandom_range(1, 64));
		endcase
		if (roll >= 66) begin
			case ($urandom_range(0, 5))
				0: d.ptype = 4'($urandom_range(TY_INVALID_FIRST, TY_INVALID_LAST));
				1: d.count = 32'd0;
				2: begin
					d.count = 32'd2;
					d.stride = 32'($urandom_range(0, esz - 1));
				end
				3: begin
					d.count = 32'd2;
					d.stride = d.stride + 32'($urandom_range(1, 3));
				end
				4: d.offset = d.offset + 32'($urandom_range(1, 3));
				default: d.dflt = span + 32'd4;
			endcase
		end
		return d;
	endfunction

	function automatic int idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: stall in random bursts, raising ready again between bursts.
	initial begin
		int n;
		out_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				n = $urandom_range(1, 8);
				out_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
				out_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result beat: status %0d accepted_count %0d",
					out_ch.status, out_ch.accepted_count);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_ch.status);
					fail_count++;
				end
				if (out_ch.accepted_count !== want.count) begin
					$error("accepted_count: expected %0d, actual %0d", want.count,
						out_ch.accepted_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(desc_t d);
		int gap;
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 8);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.start_req = d.start;
		in_ch.param_type = d.ptype;
		in_ch.elem_count = d.count;
		in_ch.elem_stride = d.stride;
		in_ch.byte_offset = d.offset;
		in_ch.default_size = d.dflt;
		do @(posedge clk); while (!in_ch.ready);
		pending_verdicts.push_back(apply_descriptor(d));
	endtask

	// Stops sending and waits for every outstanding result; ends on a falling edge.
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_buffer(logic [BUF_W-1:0] size);
		wait_idle();
		cfg_wr_data = size;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		buf_size = size;
	endtask

	task automatic test_directed();
		gap_pct = 20;
		stall_pct = 20;
		set_buffer(BUF_W'(4096));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 0, 0));
		send_item(make_desc(0, TY_SCALAR_LAST, 1, 0, 4, 4));
		send_item(make_desc(0, TY_FLOAT2, 2, 8, 8, 16));
		send_item(make_desc(0, TY_FLOAT3, 1, 0, 24, 0));
		send_item(make_desc(0, TY_FLOAT4, 3, 16, 48, 0));
		send_item(make_desc(0, TY_MATRIX4, 2, 64, 128, 0));
		send_item(make_desc(0, TY_TEXTURE, 1, 0, 0, 0));
		send_item(make_desc(0, TY_SAMPLER, 1, 0, 0, 0));
		// Hold off until the whole build so far has been reported.
		wait_idle();
		send_item(make_desc(0, TY_SCALAR_FIRST, 1, 0, 0, 0));
		send_item(make_desc(0, TY_SCALAR_FIRST, 1, 0, 512, 0));
		send_item(make_desc(1, TY_TEXTURE, 2, 0, 0, 0));
		send_item(make_desc(1, TY_INVALID_FIRST, 1, 0, 0, 0));
		send_item(make_desc(1, TY_INVALID_LAST, 1, 0, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 0, 4, 0, 0));
		send_item(make_desc(1, TY_FLOAT4, 2, 8, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 2, 6, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 2, 0));
		send_item(make_desc(1, TY_FLOAT4, 1, 0, 4088, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 4092, 0));
		send_item(make_desc(0, TY_SCALAR_FIRST, 1, 0, 256, 8));
		send_item(make_desc(1, TY_SCALAR_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 32'hFFFF_FFFC, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 0, 32'hFFFF_FFFF));
		send_item(make_desc(1, TY_SAMPLER, 1, 32'hFFFF_FFFF, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 2, 4, 0, 8));
	endtask

	task automatic test_bad_buffer();
		logic [BUF_W-1:0] sizes [3];
		sizes[0] = BUF_W'(6);
		sizes[1] = BUF_LIMIT + BUF_W'(4);
		sizes[2] = '1;
		foreach (sizes[i]) begin
			set_buffer(sizes[i]);
			send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 0, 0));
			send_item(make_desc(1, TY_TEXTURE, 1, 0, 0, 0));
			send_item(make_desc(0, TY_SCALAR_FIRST, 1, 0, 0, 0));
		end
		// A zero-sized buffer is legal but has room only for resources.
		set_buffer('0);
		send_item(make_desc(1, TY_TEXTURE, 1, 0, 0, 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 0, 0));
	endtask

	task automatic test_table_full();
		set_buffer(BUF_LIMIT);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_item(make_desc(i == 0, TY_SCALAR_FIRST, 1, 0, 32'(4 * i), 0));
		end
		send_item(make_desc(0, TY_SCALAR_FIRST, 1, 0, 32'(4 * TABLE_DEPTH), 0));
		send_item(make_desc(1, TY_SCALAR_FIRST, 1, 0, 32'(4 * TABLE_DEPTH), 0));
	endtask

	task automatic test_random_builds();
		logic [BUF_W-1:0] sizes [7];
		int n_items;
		sizes[0] = BUF_W'(4096);
		sizes[1] = BUF_LIMIT;
		sizes[2] = BUF_W'(512);
		sizes[3] = '0;
		sizes[4] = BUF_W'(4 * $urandom_range(1, 262143));
		sizes[5] = '1;
		sizes[6] = BUF_LIMIT;
		for (int p = 0; p < 7; p++) begin
			if (p == 6) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = idle_pct();
				stall_pct = idle_pct();
			end
			set_buffer(sizes[p]);
			n_items = (sizes[p] == '0 || sizes[p] > BUF_LIMIT) ? 40 : 80;
			repeat (n_items) send_item(random_desc());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.start_req = 1'b0;
		in_ch.param_type = '0;
		in_ch.elem_count = '0;
		in_ch.elem_stride = '0;
		in_ch.byte_offset = '0;
		in_ch.default_size = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_bad_buffer();
		test_table_full();
		test_random_builds();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
